FILE: rtl/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg: shared types and constants of the lidar scan segmenter
// Holds the work item passed from the front to the back and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package lss_pkg;

	localparam int RANGE_W = 16;
	localparam int LOCAL_W = 18;
	localparam int WORLD_W = 25;
	localparam int COUNT_W = 16;
	localparam int CFG_AW = 5;

	localparam logic [2:0] REG_ANGLE_START = 3'd0;
	localparam logic [2:0] REG_ANGLE_STEP = 3'd1;
	localparam logic [2:0] REG_RANGE_LIMIT = 3'd2;
	localparam logic [2:0] REG_GAP = 3'd3;
	localparam logic [2:0] REG_POSE_X = 3'd4;
	localparam logic [2:0] REG_POSE_Y = 3'd5;
	localparam logic [2:0] REG_YAW_COS = 3'd6;
	localparam logic [2:0] REG_YAW_SIN = 3'd7;

	localparam logic KIND_SEGMENT = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	// one sample as classified by the front: local point plus flags
	typedef struct packed {
		logic signed [LOCAL_W-1:0] lx;
		logic signed [LOCAL_W-1:0] ly;
		logic valid;
		logic last;
	} lss_item_t;

	typedef struct packed {
		logic kind;
		logic signed [WORLD_W-1:0] sx;
		logic signed [WORLD_W-1:0] sy;
		logic signed [WORLD_W-1:0] ex;
		logic signed [WORLD_W-1:0] ey;
		logic [COUNT_W-1:0] count;
	} lss_result_t;

	function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
		logic signed [33:0] v;
		begin
			case (i)
				5'd0: v = 34'sd536870912;
				5'd1: v = 34'sd316933406;
				5'd2: v = 34'sd167458907;
				5'd3: v = 34'sd85004756;
				5'd4: v = 34'sd42667331;
				5'd5: v = 34'sd21354465;
				5'd6: v = 34'sd10679838;
				5'd7: v = 34'sd5340245;
				5'd8: v = 34'sd2670163;
				5'd9: v = 34'sd1335087;
				5'd10: v = 34'sd667544;
				5'd11: v = 34'sd333772;
				5'd12: v = 34'sd166886;
				5'd13: v = 34'sd83443;
				5'd14: v = 34'sd41722;
				5'd15: v = 34'sd20861;
				5'd16: v = 34'sd10430;
				5'd17: v = 34'sd5215;
				5'd18: v = 34'sd2608;
				5'd19: v = 34'sd1304;
				5'd20: v = 34'sd652;
				5'd21: v = 34'sd326;
				5'd22: v = 34'sd163;
				5'd23: v = 34'sd81;
				default: v = 34'sd0;
			endcase
			return v;
		end
	endfunction

endpackage

FILE: rtl/lss_front.sv
// ----------------------------------------------------------------------------
// lss_front: sample front end
// Runs the iterative CORDIC on the beam angle, scales by range, saturates
// to the local point and hands one item to the queue.
// ----------------------------------------------------------------------------
module lss_front #(
	parameter int ANGLE_BITS = 24,
	parameter int CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [lss_pkg::RANGE_W-1:0] range_mm,
	input  logic range_invalid,
	input  logic last_of_scan,
	input  logic [ANGLE_BITS-1:0] angle_start,
	input  logic [ANGLE_BITS-1:0] angle_step,
	input  logic angle_load,
	input  logic [lss_pkg::RANGE_W-1:0] range_limit,
	output logic item_valid,
	input  logic item_ready,
	output lss_pkg::lss_item_t item
);
	import lss_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ROT = 3'd1;
	localparam logic [2:0] ST_MUL = 3'd2;
	localparam logic [2:0] ST_RND = 3'd3;
	localparam logic [2:0] ST_OUT = 3'd4;
	localparam int SW = $clog2(CORDIC_STEPS + 1);

	logic [2:0] state_q;
	logic [SW-1:0] step_q;
	logic [ANGLE_BITS-1:0] beam_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic [1:0] quad_q;
	logic [RANGE_W-1:0] range_q;
	logic valid_q, last_q;
	logic signed [51:0] px_q, py_q;
	lss_item_t item_q;

	logic [31:0] a32;
	logic signed [33:0] z0, xs, ys, c_v, s_v;
	logic [1:0] q0;
	logic signed [51:0] rx, ry;

	assign a32 = 32'(beam_q) << (32 - ANGLE_BITS);
	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;

	always_comb begin
		z0 = $signed({4'd0, a32[29:0]});
		q0 = a32[31:30];
		if (a32[29]) begin
			z0 = z0 - 34'sd1073741824;
			q0 = q0 + 2'd1;
		end
		case (quad_q)
			2'd0: begin c_v = x_q; s_v = y_q; end
			2'd1: begin c_v = -y_q; s_v = x_q; end
			2'd2: begin c_v = -x_q; s_v = -y_q; end
			default: begin c_v = y_q; s_v = -x_q; end
		endcase
		rx = px_q + 52'sd536870912;
		ry = py_q + 52'sd536870912;
	end

	function automatic logic signed [LOCAL_W-1:0] sat_local(input logic signed [51:0] v);
		logic signed [51:0] t;
		begin
			t = v >>> 30;
			if (t > 52'sd131071) return 18'sh1FFFF;
			if (t < -52'sd131072) return 18'sh20000;
			return t[LOCAL_W-1:0];
		end
	endfunction

	assign in_ready = (state_q == ST_IDLE);
	assign item_valid = (state_q == ST_OUT);
	assign item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			beam_q <= '0;
		end else begin
			if (angle_load) beam_q <= angle_start;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						range_q <= range_mm;
						valid_q <= !range_invalid && (range_mm < range_limit);
						last_q <= last_of_scan;
						x_q <= CORDIC_GAIN;
						y_q <= '0;
						z_q <= z0;
						quad_q <= q0;
						step_q <= '0;
						state_q <= ST_ROT;
					end
				end
				ST_ROT: begin
					// one micro-rotation per cycle
					if (!z_q[33]) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - atan_turn(5'(step_q));
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + atan_turn(5'(step_q));
					end
					step_q <= step_q + 1'b1;
					if (step_q == SW'(CORDIC_STEPS - 1)) state_q <= ST_MUL;
				end
				ST_MUL: begin
					px_q <= 52'($signed({1'b0, range_q})) * 52'(c_v);
					py_q <= 52'($signed({1'b0, range_q})) * 52'(s_v);
					state_q <= ST_RND;
				end
				ST_RND: begin
					item_q.lx <= sat_local(rx);
					item_q.ly <= sat_local(ry);
					item_q.valid <= valid_q;
					item_q.last <= last_q;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (item_ready) begin
						// advance the beam angle, or reload it at end of scan
						if (last_q) beam_q <= angle_start;
						else beam_q <= beam_q + angle_step;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/lss_queue.sv
// ----------------------------------------------------------------------------
// lss_queue: two-entry item queue between front and back
// ----------------------------------------------------------------------------
module lss_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  lss_pkg::lss_item_t wr_item,
	output logic rd_valid,
	input  logic rd_ready,
	output lss_pkg::lss_item_t rd_item
);
	import lss_pkg::*;

	lss_item_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_item = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				mem_q[wp_q] <= wr_item;
				wp_q <= ~wp_q;
			end
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

FILE: rtl/lss_back.sv
// ----------------------------------------------------------------------------
// lss_back: segment tracker
// Gap test, segment open/close, world transform and result register.
// ----------------------------------------------------------------------------
module lss_back (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  lss_pkg::lss_item_t item,
	input  logic [15:0] gap_threshold,
	input  logic signed [23:0] pose_x,
	input  logic signed [23:0] pose_y,
	input  logic signed [15:0] yaw_cos,
	input  logic signed [15:0] yaw_sin,
	output logic res_valid,
	input  logic res_ready,
	output lss_pkg::lss_result_t res
);
	import lss_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SQ = 4'd1;
	localparam logic [3:0] ST_DEC = 4'd2;
	localparam logic [3:0] ST_W1 = 4'd3;
	localparam logic [3:0] ST_W2 = 4'd4;
	localparam logic [3:0] ST_W3 = 4'd5;
	localparam logic [3:0] ST_FIN = 4'd6;
	localparam logic [3:0] ST_OUT = 4'd7;

	// transform destinations
	localparam logic [1:0] DST_START = 2'd0;
	localparam logic [1:0] DST_END = 2'd1;

	logic [3:0] state_q;
	lss_item_t cur_q;
	logic signed [LOCAL_W-1:0] plx_q, ply_q;
	logic pok_q, open_q;
	logic signed [WORLD_W-1:0] osx_q, osy_q;
	logic [COUNT_W-1:0] cnt_q;
	logic signed [LOCAL_W:0] dx_q, dy_q;
	logic [37:0] dx2_q, dy2_q;
	logic [31:0] g2_q;
	logic closed_q;
	logic [1:0] dst_q;
	logic signed [LOCAL_W-1:0] tx_q, ty_q;
	logic signed [34:0] m1_q, m2_q, m3_q, m4_q;
	logic signed [WORLD_W-1:0] ex_q, ey_q, sx_q, sy_q;
	lss_result_t res_q;
	logic rv_q;

	logic signed [35:0] sum_x, sum_y;
	logic signed [WORLD_W-1:0] wx, wy;
	logic [38:0] d2;
	logic near_now;

	function automatic logic signed [WORLD_W-1:0] sat_world(input logic signed [35:0] v,
		input logic signed [23:0] p);
		logic signed [35:0] t;
		begin
			t = (v >>> 14) + 36'(p);
			if (t > 36'sd16777215) return 25'sh0FFFFFF;
			if (t < -36'sd16777216) return 25'sh1000000;
			return t[WORLD_W-1:0];
		end
	endfunction

	assign sum_x = 36'(m1_q) - 36'(m2_q) + 36'sd8192;
	assign sum_y = 36'(m3_q) + 36'(m4_q) + 36'sd8192;
	assign wx = sat_world(sum_x, pose_x);
	assign wy = sat_world(sum_y, pose_y);
	assign d2 = {1'b0, dx2_q} + {1'b0, dy2_q};
	assign near_now = cur_q.valid && pok_q && (d2 <= {7'd0, g2_q});

	assign item_ready = (state_q == ST_IDLE);
	assign res_valid = rv_q;
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pok_q <= 1'b0;
			open_q <= 1'b0;
			cnt_q <= '0;
			rv_q <= 1'b0;
			plx_q <= '0;
			ply_q <= '0;
			osx_q <= '0;
			osy_q <= '0;
		end else begin
			if (rv_q && res_ready) rv_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						cur_q <= item;
						dx_q <= 19'(item.lx) - 19'(plx_q);
						dy_q <= 19'(item.ly) - 19'(ply_q);
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					dx2_q <= 38'(dx_q) * 38'(dx_q);
					dy2_q <= 38'(dy_q) * 38'(dy_q);
					g2_q <= gap_threshold * gap_threshold;
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					closed_q <= 1'b0;
					sx_q <= '0; sy_q <= '0; ex_q <= '0; ey_q <= '0;
					if (near_now && !open_q) begin
						dst_q <= DST_START;
						tx_q <= cur_q.lx; ty_q <= cur_q.ly;
						state_q <= ST_W1;
					end else if (!near_now && open_q) begin
						dst_q <= DST_END;
						tx_q <= plx_q; ty_q <= ply_q;
						state_q <= ST_W1;
					end else if (near_now && open_q && cur_q.last) begin
						dst_q <= DST_END;
						tx_q <= cur_q.lx; ty_q <= cur_q.ly;
						state_q <= ST_W1;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_W1: begin
					m1_q <= tx_q * yaw_cos;
					m2_q <= ty_q * yaw_sin;
					m3_q <= tx_q * yaw_sin;
					m4_q <= ty_q * yaw_cos;
					state_q <= ST_W2;
				end
				ST_W2: begin
					if (dst_q == DST_START) begin
						osx_q <= wx; osy_q <= wy;
						open_q <= 1'b1;
						// a segment opened on the last sample closes on it too
						if (cur_q.last) begin
							dst_q <= DST_END;
							state_q <= ST_W3;
						end else begin
							state_q <= ST_FIN;
						end
					end else begin
						closed_q <= 1'b1;
						sx_q <= osx_q; sy_q <= osy_q;
						ex_q <= wx; ey_q <= wy;
						open_q <= 1'b0;
						if (cnt_q != '1) cnt_q <= cnt_q + 1'b1;
						// an end closed at a gap on the last sample is final
						state_q <= ST_FIN;
					end
				end
				ST_W3: begin
					// copy the registered start point to the result start, then transform the end
					sx_q <= osx_q; sy_q <= osy_q;
					state_q <= ST_W1;
				end
				ST_FIN: begin
					if (!rv_q) begin
						res_q.sx <= sx_q; res_q.sy <= sy_q;
						res_q.ex <= ex_q; res_q.ey <= ey_q;
						res_q.count <= cnt_q;
						if (cur_q.last) begin
							res_q.kind <= KIND_SUMMARY;
							rv_q <= 1'b1;
							pok_q <= 1'b0;
							open_q <= 1'b0;
							cnt_q <= '0;
							plx_q <= '0; ply_q <= '0;
							osx_q <= '0; osy_q <= '0;
						end else begin
							res_q.kind <= KIND_SEGMENT;
							rv_q <= closed_q;
							plx_q <= cur_q.lx; ply_q <= cur_q.ly;
							pok_q <= cur_q.valid;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/lidar_scan_segmenter_top.sv
// ----------------------------------------------------------------------------
// lidar_scan_segmenter_top: breakpoint segmentation of a lidar scan
// Front converts range samples to local points, back tracks segments and
// reports them in world millimetres.
// ----------------------------------------------------------------------------
//  channel  direction  word
//  s_axis   in         tdata range_mm, tuser range_invalid, tlast last_of_scan
//  m_axis   out        tdata {count, ey, ex, sy, sx}, tuser result_kind
//  apb      in/out     eight registers at 4*i
//
// The front takes a sample through the CORDIC loop (one micro-rotation per
// cycle), then multiply, round and hand-off, and accepts no new sample
// until it is handed off. Front and back overlap through a two-entry queue,
// so the rate is set by the CORDIC loop unless m_axis stalls.
// Reset clears all control state and loads the register reset values.
// A stalled m_axis holds the result; the back then stops and the queue fills.
// ----------------------------------------------------------------------------
module lidar_scan_segmenter_top #(
	parameter int ANGLE_BITS = 24,
	parameter int CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [15:0] s_tdata,   // range_mm[15:0]
	input  logic s_tuser,          // range_invalid
	input  logic s_tlast,          // last_of_scan
	output logic m_tvalid,
	input  logic m_tready,
	output logic [119:0] m_tdata,  // start_x, start_y, end_x, end_y, segment_count
	output logic m_tuser,          // result_kind
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [lss_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import lss_pkg::*;

	logic [ANGLE_BITS-1:0] angle_start_q, angle_step_q;
	logic [ANGLE_BITS-1:0] angle_start_d;
	logic [15:0] range_limit_q, gap_q;
	logic signed [23:0] pose_x_q, pose_y_q;
	logic signed [15:0] yaw_cos_q, yaw_sin_q;
	logic wr_en, angle_load;
	logic [2:0] reg_idx;

	lss_item_t f_item, q_item;
	logic f_valid, f_ready, q_valid, q_ready;
	lss_result_t res;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];
	assign angle_load = wr_en && (reg_idx == REG_ANGLE_START);
	// a write of angle_start loads the beam angle with the new value at once
	assign angle_start_d = angle_load ? pwdata[ANGLE_BITS-1:0] : angle_start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_start_q <= '0;
			angle_step_q <= '0;
			range_limit_q <= 16'hFFFF;
			gap_q <= 16'd150;
			pose_x_q <= '0;
			pose_y_q <= '0;
			yaw_cos_q <= 16'sd16384;
			yaw_sin_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ANGLE_START: angle_start_q <= pwdata[ANGLE_BITS-1:0];
				REG_ANGLE_STEP: angle_step_q <= pwdata[ANGLE_BITS-1:0];
				REG_RANGE_LIMIT: range_limit_q <= pwdata[15:0];
				REG_GAP: gap_q <= pwdata[15:0];
				REG_POSE_X: pose_x_q <= pwdata[23:0];
				REG_POSE_Y: pose_y_q <= pwdata[23:0];
				REG_YAW_COS: yaw_cos_q <= pwdata[15:0];
				REG_YAW_SIN: yaw_sin_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ANGLE_START: prdata = 32'(angle_start_q);
			REG_ANGLE_STEP: prdata = 32'(angle_step_q);
			REG_RANGE_LIMIT: prdata = {16'd0, range_limit_q};
			REG_GAP: prdata = {16'd0, gap_q};
			REG_POSE_X: prdata = {8'd0, pose_x_q};
			REG_POSE_Y: prdata = {8'd0, pose_y_q};
			REG_YAW_COS: prdata = {16'd0, yaw_cos_q};
			REG_YAW_SIN: prdata = {16'd0, yaw_sin_q};
			default: prdata = '0;
		endcase
	end

	lss_front #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_front (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.range_mm(s_tdata), .range_invalid(s_tuser), .last_of_scan(s_tlast),
		.angle_start(angle_start_d), .angle_step(angle_step_q), .angle_load,
		.range_limit(range_limit_q),
		.item_valid(f_valid), .item_ready(f_ready), .item(f_item)
	);

	lss_queue u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
	);

	lss_back u_back (
		.clk, .arst_n,
		.item_valid(q_valid), .item_ready(q_ready), .item(q_item),
		.gap_threshold(gap_q), .pose_x(pose_x_q), .pose_y(pose_y_q),
		.yaw_cos(yaw_cos_q), .yaw_sin(yaw_sin_q),
		.res_valid(m_tvalid), .res_ready(m_tready), .res
	);

	assign m_tuser = res.kind;
	assign m_tdata = {4'd0, res.count, res.ey, res.ex, res.sy, res.sx};

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: lidar scan segmenter
// Streams range samples through the block under several register settings,
// predicts closed segments and scan summaries in a scoreboard, and checks
// every result word field by field.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import lss_pkg::*;

	typedef struct packed {
		logic kind;
		logic signed [24:0] sx;
		logic signed [24:0] sy;
		logic signed [24:0] ex;
		logic signed [24:0] ey;
		logic [15:0] count;
	} seg_word_t;

	// segment tracker: mirrors registers and scan state, queues expected words
	class segment_tracker;
		logic [23:0] ang_start, ang_step, beam;
		logic [15:0] rlimit, gap;
		longint px, py, ycos, ysin;
		longint prev_lx, prev_ly, open_sx, open_sy;
		bit prev_ok, seg_open;
		int unsigned closed;
		seg_word_t pending[$];
		int errors, words_checked, segs_seen, scans_seen;

		function new();
			ang_start = 0; ang_step = 0; rlimit = 16'hFFFF; gap = 16'd150;
			px = 0; py = 0; ycos = 16384; ysin = 0;
			errors = 0; words_checked = 0; segs_seen = 0; scans_seen = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			prev_lx = 0; prev_ly = 0; prev_ok = 0; beam = ang_start;
			seg_open = 0; open_sx = 0; open_sy = 0; closed = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] v);
			case (idx)
				REG_ANGLE_START: begin
					ang_start = v[23:0]; beam = v[23:0];
				end
				REG_ANGLE_STEP: ang_step = v[23:0];
				REG_RANGE_LIMIT: rlimit = v[15:0];
				REG_GAP: gap = v[15:0];
				REG_POSE_X: px = longint'($signed(v[23:0]));
				REG_POSE_Y: py = longint'($signed(v[23:0]));
				REG_YAW_COS: ycos = longint'($signed(v[15:0]));
				REG_YAW_SIN: ysin = longint'($signed(v[15:0]));
				default: ;
			endcase
		endfunction

		function longint fdiv(longint v, int s);
			return v >>> s;
		endfunction

		function longint sat(longint v, longint hi);
			if (v > hi) return hi;
			if (v < -hi - 1) return -hi - 1;
			return v;
		endfunction

		function void trig(logic [23:0] ang, output longint c, output longint s);
			logic [31:0] a32;
			int q;
			longint z, x, y, nx;
			longint atan_q[24];
			atan_q = '{536870912, 316933406, 167458907, 85004756, 42667331,
				21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
				166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
				163, 81};
			a32 = {ang, 8'h00};
			q = a32[31:30];
			z = longint'(a32[29:0]);
			x = 652032874; y = 0;
			if (z >= (64'sd1 <<< 29)) begin
				z -= 64'sd1 <<< 30; q = (q + 1) % 4;
			end
			for (int i = 0; i < 16; i++) begin
				if (z >= 0) begin
					nx = x - fdiv(y, i); y = y + fdiv(x, i); z -= atan_q[i];
				end else begin
					nx = x + fdiv(y, i); y = y - fdiv(x, i); z += atan_q[i];
				end
				x = nx;
			end
			case (q)
				0: begin c = x; s = y; end
				1: begin c = -y; s = x; end
				2: begin c = -x; s = -y; end
				default: begin c = y; s = -x; end
			endcase
		endfunction

		function void place(longint lx, longint ly, output longint wx, output longint wy);
			wx = sat(px + fdiv(lx * ycos - ly * ysin + 8192, 14), 16777215);
			wy = sat(py + fdiv(lx * ysin + ly * ycos + 8192, 14), 16777215);
		endfunction

		function void note_sample(logic [15:0] rng, bit inval, bit last);
			longint c, s, lx, ly, sx, sy, ex, ey, dx, dy;
			bit ok, near, closed_now;
			seg_word_t w;
			sx = 0; sy = 0; ex = 0; ey = 0; near = 0; closed_now = 0;
			trig(beam, c, s);
			lx = sat(fdiv(longint'(rng) * c + (64'sd1 <<< 29), 30), 131071);
			ly = sat(fdiv(longint'(rng) * s + (64'sd1 <<< 29), 30), 131071);
			ok = !inval && rng < rlimit;
			if (ok && prev_ok) begin
				dx = lx - prev_lx; dy = ly - prev_ly;
				near = (dx * dx + dy * dy) <= longint'(gap) * longint'(gap);
			end
			if (near) begin
				if (!seg_open) begin
					seg_open = 1; place(lx, ly, open_sx, open_sy);
				end
			end else if (seg_open) begin
				closed_now = 1; sx = open_sx; sy = open_sy;
				place(prev_lx, prev_ly, ex, ey);
				seg_open = 0;
				if (closed < 65535) closed++;
			end
			if (last) begin
				if (seg_open) begin
					closed_now = 1; sx = open_sx; sy = open_sy;
					place(lx, ly, ex, ey);
					if (closed < 65535) closed++;
				end
				w = '{KIND_SUMMARY, sx[24:0], sy[24:0], ex[24:0], ey[24:0], closed[15:0]};
				pending = {pending, w};
				clear_scan();
				return;
			end
			prev_lx = lx; prev_ly = ly; prev_ok = ok;
			beam = beam + ang_step;
			if (closed_now) begin
				w = '{KIND_SEGMENT, sx[24:0], sy[24:0], ex[24:0], ey[24:0], closed[15:0]};
				pending = {pending, w};
			end
		endfunction

		function void check_word(seg_word_t got);
			seg_word_t exp_w;
			words_checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word %h", $realtime, got);
				errors++;
				return;
			end
			exp_w = pending.pop_front();
			if (exp_w.kind) scans_seen++; else segs_seen++;
			if (got.kind !== exp_w.kind) begin
				$display("%0t: kind exp %0d got %0d", $realtime, exp_w.kind, got.kind); errors++;
			end
			if (got.sx !== exp_w.sx) begin
				$display("%0t: start_x exp %0d got %0d", $realtime, exp_w.sx, got.sx); errors++;
			end
			if (got.sy !== exp_w.sy) begin
				$display("%0t: start_y exp %0d got %0d", $realtime, exp_w.sy, got.sy); errors++;
			end
			if (got.ex !== exp_w.ex) begin
				$display("%0t: end_x exp %0d got %0d", $realtime, exp_w.ex, got.ex); errors++;
			end
			if (got.ey !== exp_w.ey) begin
				$display("%0t: end_y exp %0d got %0d", $realtime, exp_w.ey, got.ey); errors++;
			end
			if (got.count !== exp_w.count) begin
				$display("%0t: count exp %0d got %0d", $realtime, exp_w.count, got.count);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [15:0] s_tdata = '0;     // range_mm[15:0]
	logic s_tuser = 0;             // range_invalid
	logic s_tlast = 0;             // last_of_scan
	logic m_tvalid;
	logic m_tready = 0;
	logic [119:0] m_tdata;         // start_x, start_y, end_x, end_y, segment_count
	logic m_tuser;                 // result_kind
	logic psel = 0, penable = 0, pwrite = 0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	segment_tracker board = new();
	bit quiet_phase = 0;           // no idling in the last part of the run
	int idle_cycles = 0;
	int samples_sent = 0;

	lidar_scan_segmenter_top u_top (.*);

	always #6 clk = ~clk;

	// receiver: check accepted words, stall in random bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				board.check_word({m_tuser, m_tdata[24:0], m_tdata[49:25],
					m_tdata[74:50], m_tdata[99:75], m_tdata[115:100]});
		end
	end

	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			m_tready <= 1;
			n = $urandom_range(1, 6);
			repeat (n) @(posedge clk);
			if (!quiet_phase) begin
				m_tready <= 0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
		end
	end

	// watchdog: end the run after a long stretch with no handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 2000) begin
			$display("%0t: watchdog timeout", $realtime);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= CFG_AW'(idx) << 2; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		board.write_reg(idx, v);
	endtask

	// send one sample, hold valid until accepted, optionally idle afterwards
	task automatic send_sample(logic [15:0] rng, bit inval, bit last);
		s_tvalid <= 1;
		s_tdata <= rng;
		s_tuser <= inval;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_sample(rng, inval, last);
		samples_sent++;
		if (!quiet_phase && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic stop_sending();
		s_tvalid <= 0;
	endtask

	// drain: wait for all words, then let the block finish any silent sample
	task automatic drain();
		stop_sending();
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// one scan: mostly smooth wall runs with gaps, some noise
	task automatic send_scan(int len, int base);
		int r;
		r = base;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 9))
				0: r = $urandom_range(0, 65535);
				1: r = r + $urandom_range(200, 3000);
				default: r = r + $urandom_range(0, 40) - 20;
			endcase
			if (r < 0) r = 50;
			if (r > 65535) r = 65000;
			send_sample(r[15:0], $urandom_range(0, 15) == 0, i == len - 1);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset settings, extremes of range, invalid, last on a segment
		send_sample(16'd1000, 0, 0);
		send_sample(16'd1010, 0, 0);
		send_sample(16'd1020, 0, 0);
		send_sample(16'd5000, 0, 0);
		send_sample(16'd5010, 0, 0);
		send_sample(16'd5020, 1, 0);
		send_sample(16'd0, 0, 0);
		send_sample(16'd0, 0, 0);
		send_sample(16'hFFFF, 0, 0);
		send_sample(16'hFFFE, 0, 0);
		send_sample(16'd7000, 0, 0);
		send_sample(16'd7005, 0, 1);
		send_sample(16'd300, 0, 1);
		drain();

		// extremes of every register
		write_reg(REG_ANGLE_START, 32'hFFFFFF);
		write_reg(REG_ANGLE_STEP, 32'h800000);
		write_reg(REG_RANGE_LIMIT, 32'd0);
		write_reg(REG_GAP, 32'hFFFF);
		write_reg(REG_POSE_X, 32'h7FFFFF);
		write_reg(REG_POSE_Y, 32'h800000);
		write_reg(REG_YAW_COS, 32'hFFFF_C000);
		write_reg(REG_YAW_SIN, 32'h4000);
		send_sample(16'd100, 0, 0);
		send_sample(16'd100, 0, 1);
		drain();
		write_reg(REG_RANGE_LIMIT, 32'hFFFF);
		send_sample(16'hFFFE, 0, 0);
		send_sample(16'hFFFE, 0, 0);
		send_sample(16'hFFFE, 0, 0);
		send_sample(16'd0, 1, 1);
		drain();
		write_reg(REG_GAP, 32'd0);
		send_sample(16'd500, 0, 0);
		send_sample(16'd500, 0, 0);
		send_sample(16'd500, 0, 1);
		drain();

		// random settings and scans
		for (int p = 0; p < 10; p++) begin
			write_reg(REG_ANGLE_START, $urandom());
			write_reg(REG_ANGLE_STEP, (p % 2) ? $urandom() : $urandom_range(0, 40000));
			write_reg(REG_RANGE_LIMIT, $urandom_range(20000, 65535));
			write_reg(REG_GAP, $urandom_range(20, 400));
			write_reg(REG_POSE_X, $urandom());
			write_reg(REG_POSE_Y, $urandom());
			write_reg(REG_YAW_COS, $urandom_range(0, 32768) - 16384);
			write_reg(REG_YAW_SIN, $urandom_range(0, 32768) - 16384);
			if (p == 8) quiet_phase = 1;
			for (int k = 0; k < 3; k++)
				send_scan($urandom_range(5, 35), $urandom_range(100, 20000));
			drain();
		end

		$display("Sent %0d samples under reset, extreme and 10 random register sets;",
			samples_sent);
		$display("  checked %0d words (%0d closed segments, %0d scan summaries)",
			board.words_checked, board.segs_seen, board.scans_seen);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
